FILE: design/gst_pkg.sv
// Shared constants, codes and controller/datapath interface types of the subscription table.
`default_nettype none
package gst_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);
  localparam int GEN_W   = 16;
  localparam int TOK_W   = 32;
  localparam int MSLOT_W = 6;
  localparam int TGT_W   = 16;
  localparam int DATA_W  = 32;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_DISPATCH   = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_REJECT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_STALE   = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  typedef struct packed {
    logic    load_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    write_slot;
    logic    free_slot;
    logic    clear_all;
    logic    pend_load;
    logic    out_load;
    status_e out_status;
    logic    out_last;
    logic    out_token;
    logic    out_match;
  } gst_cmd_t;

  typedef struct packed {
    logic target_null;
    logic free_here;
    logic idx_last;
    logic token_zero;
    logic token_ok;
    logic hit;
    logic pend_valid;
    logic cnt_full_next;
    logic out_free;
  } gst_stat_t;

endpackage
`default_nettype wire

FILE: design/generational_subscription_table_core.sv
// Top level: stream ports, APB configuration register, controller and datapath.
// Register runs a free-slot search, one slot per cycle. Only one item is handled at a time;
// the next item is taken in the cycle after the last result beat of the previous one is loaded.
// Reset: every slot is free, the generation counter is one, the all-events mask is all ones.
`default_nettype none
module generational_subscription_table_core
  import gst_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // target_id[15:0], target_static[16], scene_id[48:17], event_bits[80:49], token_in[112:81]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // token_out[31:0], match_slot[37:32], match_target[53:38], match_static[54]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // status[2:0]
  output logic [2:0]                  m_axis_tuser,
  output logic                        m_axis_tlast,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready
);

  gst_cmd_t          cmd;
  gst_stat_t         stat;
  logic [DATA_W-1:0] all_events_mask_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? all_events_mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_events_mask_q <= '1;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      all_events_mask_q <= pwdata;
    end
  end

  gst_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_type_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gst_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .all_events_mask_i (all_events_mask_q),
    .in_tdata_i        (s_axis_tdata),
    .out_tvalid_o      (m_axis_tvalid),
    .out_tready_i      (m_axis_tready),
    .out_tdata_o       (m_axis_tdata),
    .out_tuser_o       (m_axis_tuser),
    .out_tlast_o       (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: design/gst_datapath.sv
// Datapath: slot table, input latch, walk index, pending match and output beat register.
`default_nettype none
module gst_datapath
  import gst_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire gst_cmd_t               cmd_i,
  output gst_stat_t                   stat_o,
  input  wire logic [DATA_W-1:0]      all_events_mask_i,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata_i,
  output logic                        out_tvalid_o,
  input  wire logic                   out_tready_i,
  output logic [OUT_TDATA_W-1:0]      out_tdata_o,
  output logic [2:0]                  out_tuser_o,
  output logic                        out_tlast_o
);

  logic [TGT_W-1:0]  target_q;
  logic              static_q;
  logic [DATA_W-1:0] scene_q;
  logic [DATA_W-1:0] bits_q;
  logic [TOK_W-1:0]  token_q;

  logic [GEN_W-1:0]  gen_q [SLOTS];
  logic [TGT_W-1:0]  tgt_q [SLOTS];
  logic              stc_q [SLOTS];
  logic [DATA_W-1:0] filter_q [SLOTS];
  logic [DATA_W-1:0] mask_q [SLOTS];

  logic [GEN_W-1:0]  next_gen_q, next_gen_inc;
  logic [SLOT_W-1:0] idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              pend_valid_q;
  logic [SLOT_W-1:0] pend_slot_q;
  logic [TGT_W-1:0]  pend_tgt_q;
  logic              pend_stc_q;

  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [TOK_W-1:0]  out_token_q;
  logic [MSLOT_W-1:0] out_slot_q;
  logic [TGT_W-1:0]  out_tgt_q;
  logic              out_stc_q;
  logic              out_last_q;

  logic [15:0]       tok_slot;
  logic [GEN_W-1:0]  tok_gen;
  logic [SLOT_W-1:0] tok_idx;
  logic              hit;
  logic              out_free;

  assign tok_slot = token_q[15:0];
  assign tok_gen  = token_q[31:16];
  assign tok_idx  = tok_slot[SLOT_W-1:0];
  assign out_free = !out_valid_q || out_tready_i;

  assign next_gen_inc = (next_gen_q == {GEN_W{1'b1}}) ? GEN_W'(1) : next_gen_q + GEN_W'(1);

  assign hit = (gen_q[idx_q] != '0) && ((mask_q[idx_q] & bits_q) != '0) &&
               ((filter_q[idx_q] == '0) || (filter_q[idx_q] == scene_q));

  always_comb begin
    stat_o.target_null   = (target_q == '0);
    stat_o.free_here     = (gen_q[idx_q] == '0);
    stat_o.idx_last      = (idx_q == SLOT_W'(SLOTS - 1));
    stat_o.token_zero    = (token_q == '0);
    stat_o.token_ok      = (tok_slot < 16'(SLOTS)) && (tok_gen != '0) &&
                           (gen_q[tok_idx] == tok_gen);
    stat_o.hit           = hit;
    stat_o.pend_valid    = pend_valid_q;
    stat_o.cnt_full_next = (cnt_q == CNT_W'(MAX_OUT - 1));
    stat_o.out_free      = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      target_q <= in_tdata_i[15:0];
      static_q <= in_tdata_i[16];
      scene_q  <= in_tdata_i[48:17];
      bits_q   <= in_tdata_i[80:49];
      token_q  <= in_tdata_i[112:81];
    end
    if (cmd_i.write_slot) begin
      tgt_q[idx_q]    <= target_q;
      stc_q[idx_q]    <= static_q;
      filter_q[idx_q] <= scene_q;
      mask_q[idx_q]   <= (bits_q == '0) ? all_events_mask_i : bits_q;
    end
    if (cmd_i.pend_load) begin
      pend_slot_q <= idx_q;
      pend_tgt_q  <= tgt_q[idx_q];
      pend_stc_q  <= stc_q[idx_q];
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
      out_token_q  <= cmd_i.out_token ? {next_gen_q, 16'(idx_q)} : '0;
      out_slot_q   <= cmd_i.out_match ? MSLOT_W'(pend_slot_q) : '0;
      out_tgt_q    <= cmd_i.out_match ? pend_tgt_q : '0;
      out_stc_q    <= cmd_i.out_match ? pend_stc_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        gen_q[i] <= '0;
      end
      next_gen_q   <= GEN_W'(1);
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_all) begin
        for (int i = 0; i < SLOTS; i++) begin
          gen_q[i] <= '0;
        end
      end else if (cmd_i.write_slot) begin
        gen_q[idx_q] <= next_gen_q;
      end else if (cmd_i.free_slot) begin
        gen_q[tok_idx] <= '0;
      end
      if (cmd_i.write_slot) begin
        next_gen_q <= next_gen_inc;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (cmd_i.load_req) begin
        cnt_q        <= '0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.pend_load) begin
        cnt_q        <= cnt_q + CNT_W'(1);
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {1'b0, out_stc_q, out_tgt_q, out_slot_q, out_token_q};
  assign out_tuser_o  = out_status_q;
  assign out_tlast_o  = out_last_q;

endmodule
`default_nettype wire

FILE: design/gst_controller.sv
// Controller state machine: sequences register search, unregister, dispatch walk and clear.
`default_nettype none
module gst_controller
  import gst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic [1:0] in_type_i,
  output logic           in_ready_o,
  input  wire gst_stat_t stat_i,
  output gst_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REG_SCAN,
    S_UNREG,
    S_WALK,
    S_FINISH,
    S_CLEAR
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          unique case (req_e'(in_type_i))
            REQ_REGISTER:   state_d = S_REG_SCAN;
            REQ_UNREGISTER: state_d = S_UNREG;
            REQ_DISPATCH:   state_d = S_WALK;
            REQ_CLEAR:      state_d = S_CLEAR;
            default:        state_d = S_IDLE;
          endcase
        end
      end
      S_REG_SCAN: begin
        cmd_o.out_last = 1'b1;
        if (stat_i.target_null) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_REJECT;
            state_d          = S_IDLE;
          end
        end else if (stat_i.free_here) begin
          if (stat_i.out_free) begin
            cmd_o.write_slot = 1'b1;
            cmd_o.out_load   = 1'b1;
            cmd_o.out_token  = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (stat_i.idx_last) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_FULL;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_UNREG: begin
        cmd_o.out_last = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
          if (stat_i.token_zero) begin
            cmd_o.out_status = ST_REJECT;
          end else if (stat_i.token_ok) begin
            cmd_o.free_slot = 1'b1;
          end else begin
            cmd_o.out_status = ST_STALE;
          end
        end
      end
      S_WALK: begin
        if (stat_i.hit) begin
          if (!stat_i.pend_valid || stat_i.out_free) begin
            cmd_o.out_load  = stat_i.pend_valid;
            cmd_o.out_match = 1'b1;
            cmd_o.pend_load = 1'b1;
            if (stat_i.cnt_full_next || stat_i.idx_last) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.idx_inc = 1'b1;
            end
          end
        end else if (stat_i.idx_last) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.out_last = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_match  = stat_i.pend_valid;
          cmd_o.out_status = stat_i.pend_valid ? ST_OK : ST_NOMATCH;
          state_d          = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.out_last = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.clear_all = 1'b1;
          cmd_o.out_load  = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
